[hdl/adz_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// adz_pkg
// Shared types and constants of the axis dead-zone scaler.
// ============================================================================
package adz_pkg;

    localparam int DZ_W       = 16;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int POS_W      = 8;

    localparam logic [CFG_IDX_W-1:0] REG_CENTRE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_POS_SPAN = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_NEG_SPAN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INNER_DZ = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_OUTER_DZ = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TRUNCATE = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_INVERT   = 3'd6;

    localparam logic [CFG_DATA_W-1:0] RST_CENTRE   = 16'd512;
    localparam logic [CFG_DATA_W-1:0] RST_SPAN     = 16'd512;
    localparam logic [DZ_W-1:0]       RST_INNER_DZ = 16'd3277;
    localparam logic [DZ_W-1:0]       RST_OUTER_DZ = 16'd29491;

    typedef enum logic [1:0] {
        KIND_ZERO,
        KIND_FULL,
        KIND_DIV
    } t_adz_kind;

    typedef struct packed {
        logic      valid;
        logic      neg;
        t_adz_kind kind;
    } t_adz_tag;

endpackage
`default_nettype wire

[hdl/adz_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// adz_front
// Centre removal, threshold products, classification and numerator scaling;
// four register stages ahead of the divider.
// ============================================================================
module adz_front
    import adz_pkg::*;
#(
    parameter int FULL_SCALE    = 127,
    parameter int SAMPLE_BITS   = 10,
    parameter int FRACTION_BITS = 15
) (
    input  wire logic                                         i_clk,
    input  wire logic                                         i_rst_n,
    input  wire logic                                         i_en,
    input  wire logic                                         i_valid,
    input  wire logic [SAMPLE_BITS-1:0]                       i_sample,
    input  wire logic [SAMPLE_BITS-1:0]                       i_centre,
    input  wire logic [SAMPLE_BITS-1:0]                       i_pos_span,
    input  wire logic [SAMPLE_BITS-1:0]                       i_neg_span,
    input  wire logic [DZ_W-1:0]                              i_inner_dz,
    input  wire logic [DZ_W-1:0]                              i_outer_dz,
    input  wire logic                                         i_truncate,
    input  wire logic                                         i_invert,
    output t_adz_tag                                          o_tag,
    output logic [SAMPLE_BITS+DZ_W+$clog2(FULL_SCALE+1)-1:0]  o_num,
    output logic [SAMPLE_BITS+DZ_W-1:0]                       o_den
);

    localparam int QB = $clog2(FULL_SCALE + 1);
    localparam int LW = SAMPLE_BITS + DZ_W;
    localparam int NW = LW + QB;
    localparam int MW = SAMPLE_BITS + QB;

    // stage 1
    logic                   r1_valid;
    logic                   r1_neg;
    logic [SAMPLE_BITS-1:0] r1_mag;
    logic [SAMPLE_BITS-1:0] r1_span;
    logic                   n1_below;
    logic [SAMPLE_BITS-1:0] n1_mag;
    logic [SAMPLE_BITS-1:0] n1_span;

    // stage 2
    logic                   r2_valid;
    logic                   r2_neg;
    logic                   r2_mag_zero;
    logic [LW-1:0]          r2_mag_q;
    logic [MW-1:0]          r2_mag_fs;
    logic [SAMPLE_BITS-1:0] r2_span;
    logic [LW-1:0]          r2_in_lim;
    logic [LW-1:0]          r2_out_lim;

    // stage 3
    t_adz_tag               r3_tag;
    logic                   r3_scale;
    logic [LW-1:0]          r3_num;
    logic [LW-1:0]          r3_den;
    t_adz_kind              n3_kind;
    logic                   n3_ovf;

    // stage 4
    t_adz_tag               r4_tag;
    logic [NW-1:0]          r4_num;
    logic [LW-1:0]          r4_den;

    always_comb begin
        n1_below = i_sample < i_centre;
        n1_mag   = n1_below ? (i_centre - i_sample) : (i_sample - i_centre);
        n1_span  = n1_below ? i_neg_span : i_pos_span;
        if (n1_span == '0) begin
            n1_span = SAMPLE_BITS'(1);
        end
    end

    always_comb begin
        n3_ovf = r2_mag_fs >= (MW'(r2_span) << QB);
        priority if (r2_mag_zero || (r2_mag_q < r2_in_lim)) begin
            n3_kind = KIND_ZERO;
        end else if (r2_mag_q >= r2_out_lim) begin
            n3_kind = KIND_FULL;
        end else if (i_truncate && n3_ovf) begin
            n3_kind = KIND_FULL;
        end else begin
            n3_kind = KIND_DIV;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_tag   <= '0;
            r4_tag   <= '0;
        end else if (i_en) begin
            r1_valid <= i_valid;
            r2_valid <= r1_valid;
            r3_tag   <= '{valid: r2_valid, neg: r2_neg, kind: n3_kind};
            r4_tag   <= r3_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_neg      <= n1_below ^ i_invert;
            r1_mag      <= n1_mag;
            r1_span     <= n1_span;

            r2_neg      <= r1_neg;
            r2_mag_zero <= r1_mag == '0;
            r2_mag_q    <= LW'(r1_mag) << FRACTION_BITS;
            r2_mag_fs   <= MW'(r1_mag) * MW'(FULL_SCALE);
            r2_span     <= r1_span;
            r2_in_lim   <= LW'(i_inner_dz) * LW'(r1_span);
            r2_out_lim  <= LW'(i_outer_dz) * LW'(r1_span);

            r3_scale    <= !i_truncate;
            if (i_truncate) begin
                r3_num <= LW'(r2_mag_fs);
                r3_den <= LW'(r2_span);
            end else begin
                r3_num <= r2_mag_q - r2_in_lim;
                r3_den <= r2_out_lim - r2_in_lim;
            end

            r4_num      <= r3_scale ? (NW'(r3_num) * NW'(FULL_SCALE)) : NW'(r3_num);
            r4_den      <= r3_den;
        end
    end

    assign o_tag = r4_tag;
    assign o_num = r4_num;
    assign o_den = r4_den;

endmodule
`default_nettype wire

[hdl/adz_div.sv]
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// adz_div
// Pipelined restoring divider, one quotient bit per register stage.
// ============================================================================
module adz_div
    import adz_pkg::*;
#(
    parameter int NW = 33,
    parameter int DW = 26,
    parameter int QB = 7
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_en,
    input  wire t_adz_tag      i_tag,
    input  wire logic [NW-1:0] i_num,
    input  wire logic [DW-1:0] i_den,
    output t_adz_tag           o_tag,
    output logic [QB-1:0]      o_quot
);

    t_adz_tag      r_tag [0:QB-1];
    logic [NW-1:0] r_rem [0:QB-1];
    logic [DW-1:0] r_den [0:QB-1];
    logic [QB-1:0] r_quo [0:QB-1];

    for (genvar k = 0; k < QB; k++) begin : g_stage
        localparam int B = QB - 1 - k;
        t_adz_tag      w_tag;
        logic [NW-1:0] w_rem;
        logic [DW-1:0] w_den;
        logic [QB-1:0] w_quo;
        logic [NW-1:0] w_sub;

        if (k == 0) begin : g_first
            assign w_tag = i_tag;
            assign w_rem = i_num;
            assign w_den = i_den;
            assign w_quo = '0;
        end else begin : g_next
            assign w_tag = r_tag[k-1];
            assign w_rem = r_rem[k-1];
            assign w_den = r_den[k-1];
            assign w_quo = r_quo[k-1];
        end

        assign w_sub = NW'(w_den) << B;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_tag[k] <= '0;
            end else if (i_en) begin
                r_tag[k] <= w_tag;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_den[k] <= w_den;
                if (w_rem >= w_sub) begin
                    r_rem[k]    <= w_rem - w_sub;
                    r_quo[k]    <= w_quo | (QB'(1) << B);
                end else begin
                    r_rem[k]    <= w_rem;
                    r_quo[k]    <= w_quo;
                end
            end
        end
    end

    assign o_tag  = r_tag[QB-1];
    assign o_quot = r_quo[QB-1];

endmodule
`default_nettype wire

[hdl/axis_dead_zone_scaler.sv]
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// axis_dead_zone_scaler
// Dead-zone calibration and scaling of one analog axis sample.
// ============================================================================
// Use:
//   s_axis carries one ADC sample per word, m_axis one signed position per
//   word. Calibration registers are written through i_cfg_we / i_cfg_idx /
//   i_cfg_data while no word is in flight.
// Path: an accepted input word reaches its output word through four front
//   stages, one divider stage per quotient bit, and the output register.
// Throughput: one word per cycle while the output is not stalled; every stage advances together.
// Reset: all stages empty, m_axis_tvalid low, s_axis_tready low while reset
//   is held, registers at their reset values (centre and spans 512, dead
//   zones 3277 and 29491, stretch mode, no inversion).
// Stall: while m_axis_tvalid is high and m_axis_tready low, the whole
//   pipeline holds and s_axis_tready is low; no word is dropped or repeated.
// ============================================================================
module axis_dead_zone_scaler
    import adz_pkg::*;
#(
    parameter int FULL_SCALE    = 127,
    parameter int SAMPLE_BITS   = 10,
    parameter int FRACTION_BITS = 15
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    input  wire logic [((SAMPLE_BITS+7)/8)*8-1:0]   s_axis_tdata,  // [sample]
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    output logic [POS_W-1:0]                        m_axis_tdata,  // [position]
    input  wire logic                               i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]               i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0]              i_cfg_data
);

    localparam int QB = $clog2(FULL_SCALE + 1);
    localparam int LW = SAMPLE_BITS + DZ_W;
    localparam int NW = LW + QB;

    logic [SAMPLE_BITS-1:0] r_centre;
    logic [SAMPLE_BITS-1:0] r_pos_span;
    logic [SAMPLE_BITS-1:0] r_neg_span;
    logic [DZ_W-1:0]        r_inner_dz;
    logic [DZ_W-1:0]        r_outer_dz;
    logic                   r_truncate;
    logic                   r_invert;

    logic                   w_en;
    t_adz_tag               w_front_tag;
    logic [NW-1:0]          w_front_num;
    logic [LW-1:0]          w_front_den;
    t_adz_tag               w_div_tag;
    logic [QB-1:0]          w_div_quot;

    logic                   r_out_valid;
    logic [POS_W-1:0]       r_out_pos;
    logic [QB-1:0]          n_mag;
    logic [POS_W-1:0]       n_mag_w;

    assign w_en = !r_out_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_centre   <= RST_CENTRE[SAMPLE_BITS-1:0];
            r_pos_span <= RST_SPAN[SAMPLE_BITS-1:0];
            r_neg_span <= RST_SPAN[SAMPLE_BITS-1:0];
            r_inner_dz <= RST_INNER_DZ;
            r_outer_dz <= RST_OUTER_DZ;
            r_truncate <= 1'b0;
            r_invert   <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_CENTRE:   r_centre   <= i_cfg_data[SAMPLE_BITS-1:0];
                REG_POS_SPAN: r_pos_span <= i_cfg_data[SAMPLE_BITS-1:0];
                REG_NEG_SPAN: r_neg_span <= i_cfg_data[SAMPLE_BITS-1:0];
                REG_INNER_DZ: r_inner_dz <= i_cfg_data[DZ_W-1:0];
                REG_OUTER_DZ: r_outer_dz <= i_cfg_data[DZ_W-1:0];
                REG_TRUNCATE: r_truncate <= i_cfg_data[0];
                REG_INVERT:   r_invert   <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    adz_front #(
        .FULL_SCALE    (FULL_SCALE),
        .SAMPLE_BITS   (SAMPLE_BITS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (w_en),
        .i_valid    (s_axis_tvalid),
        .i_sample   (s_axis_tdata[SAMPLE_BITS-1:0]),
        .i_centre   (r_centre),
        .i_pos_span (r_pos_span),
        .i_neg_span (r_neg_span),
        .i_inner_dz (r_inner_dz),
        .i_outer_dz (r_outer_dz),
        .i_truncate (r_truncate),
        .i_invert   (r_invert),
        .o_tag      (w_front_tag),
        .o_num      (w_front_num),
        .o_den      (w_front_den)
    );

    adz_div #(
        .NW (NW),
        .DW (LW),
        .QB (QB)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_tag   (w_front_tag),
        .i_num   (w_front_num),
        .i_den   (w_front_den),
        .o_tag   (w_div_tag),
        .o_quot  (w_div_quot)
    );

    always_comb begin
        unique case (w_div_tag.kind)
            KIND_ZERO: n_mag = '0;
            KIND_FULL: n_mag = QB'(FULL_SCALE);
            KIND_DIV:  n_mag = (w_div_quot > QB'(FULL_SCALE)) ? QB'(FULL_SCALE) : w_div_quot;
            default:   n_mag = '0;
        endcase
        n_mag_w = POS_W'(n_mag);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= w_div_tag.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_pos <= w_div_tag.neg ? (POS_W'(0) - n_mag_w) : n_mag_w;
        end
    end

    assign s_axis_tready = w_en && i_rst_n;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_pos;

endmodule
`default_nettype wire
